@@ design/sdjo_pkg.sv @@
package sdjo_pkg;

    localparam int FIELD_W    = 48;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_COST_MODE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELATION_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_CAP       = 2'd2;

    typedef enum logic [1:0] {
        MODE_MIN_PLUS = 2'd0,
        MODE_MIN_MAX  = 2'd1,
        MODE_HASH     = 2'd2,
        MODE_APPROX   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_FINAL,
        S_DONE
    } t_state;

    // Control from the sequencer to the split evaluator.
    typedef struct packed {
        logic  clear;
        logic  load_vld;
        t_mode mode;
    } t_eval_ctl;

endpackage

@@ design/sdjo_table.sv @@
module sdjo_table #(
    parameter int AW = 12,
    parameter int DW = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

@@ design/sdjo_split_eval.sv @@
module sdjo_split_eval #(
    parameter int CW = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdjo_pkg::t_eval_ctl  i_ctl,
    input  logic [2*CW-1:0]      i_rd_a,
    input  logic [2*CW-1:0]      i_rd_b,
    output logic [CW-1:0]        o_best,
    output logic                 o_pending
);

    import sdjo_pkg::*;

    localparam logic [CW-1:0] COST_INF    = '1;
    localparam logic [CW-1:0] COST_MAXFIN = {{(CW-1){1'b1}}, 1'b0};

    logic [CW-1:0] ca, cb, sa, sb;
    logic [CW-1:0] cost_max, size_min, cand;
    logic [CW:0]   sum;
    logic          both_finite;
    logic [CW-1:0] r_cand, r_best;
    logic          r_cand_vld;

    always_comb begin
        ca          = i_rd_a[CW-1:0];
        sa          = i_rd_a[2*CW-1:CW];
        cb          = i_rd_b[CW-1:0];
        sb          = i_rd_b[2*CW-1:CW];
        both_finite = (ca != COST_INF) && (cb != COST_INF);
        sum         = {1'b0, ca} + {1'b0, cb};
        cost_max    = (ca > cb) ? ca : cb;
        size_min    = (sa < sb) ? sa : sb;
        case (i_ctl.mode) inside
            MODE_MIN_PLUS: cand = (sum > {1'b0, COST_MAXFIN}) ? COST_MAXFIN : sum[CW-1:0];
            MODE_HASH:     cand = (cost_max > size_min) ? cost_max : size_min;
            MODE_MIN_MAX, MODE_APPROX: cand = cost_max;
            default:       cand = cost_max;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
        end else begin
            r_cand_vld <= i_ctl.load_vld && both_finite && !i_ctl.clear;
        end
    end

    // The candidate is registered before the running minimum is updated.
    always_ff @(posedge i_clk) begin
        r_cand <= cand;
        if (i_ctl.clear) begin
            r_best <= COST_INF;
        end else if (r_cand_vld && (r_cand < r_best)) begin
            r_best <= r_cand;
        end
    end

    assign o_best    = r_best;
    assign o_pending = r_cand_vld;

endmodule

@@ design/subset_dp_join_order_cost_top.sv @@
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      i_subset_size, i_unconnected
// result    out        o_result_valid (1 cycle)  o_subset_cost, o_cost_finite, o_full_set
// config    in         i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A subset of two or more relations that is not unconnected or pruned goes through setup,
// a submask scan, a drain and a final step before its result strobe; empty,
// single-relation, unconnected and pruned subsets go from setup straight to the strobe.
// Start is accepted again in the cycle after the strobe. The scan reads both parts of one
// split per cycle from the dual-read cost table and passes them through one shared evaluator.
// Reset is synchronous and active low; the tables are not cleared; the receiver cannot stall.
module subset_dp_join_order_cost_top #(
    parameter int MAX_RELATIONS = 12,
    parameter int COST_WIDTH    = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [sdjo_pkg::FIELD_W-1:0]         i_subset_size,
    input  logic                                 i_unconnected,
    output logic                                 o_result_valid,
    output logic [sdjo_pkg::FIELD_W-1:0]         o_subset_cost,
    output logic                                 o_cost_finite,
    output logic                                 o_full_set,
    input  logic                                 i_cfg_we,
    input  logic [sdjo_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [sdjo_pkg::FIELD_W-1:0]         i_cfg_wdata
);

    import sdjo_pkg::*;

    localparam int MR = MAX_RELATIONS;
    localparam int CW = COST_WIDTH;
    localparam int EW = (CW > FIELD_W) ? CW : FIELD_W;

    localparam logic [CW-1:0] COST_INF    = '1;
    localparam logic [CW-1:0] COST_MAXFIN = {{(CW-1){1'b1}}, 1'b0};
    localparam logic [EW-1:0] MAXFIN_E    = EW'(COST_MAXFIN);

    t_state            r_state, n_state;
    t_mode             r_cost_mode;
    logic [3:0]        r_rel_count;
    logic [FIELD_W-1:0] r_size_cap;

    logic [MR-1:0]     r_counter, r_s, r_mask, r_a;
    logic [CW-1:0]     r_size, r_pow, r_best;
    logic              r_unconn, r_rd_vld;

    logic [4:0]        rc_ext, n_eff;
    logic [MR-1:0]     mask, a_next;
    logic [EW-1:0]     raw_e;
    logic              in_unconn, accept;
    logic [CW-1:0]     in_size, smear, pow, final_best;
    logic [CW:0]       final_sum;
    logic              trivial, pruned, last_split, issue;

    t_eval_ctl         eval_ctl;
    logic [CW-1:0]     eval_best;
    logic              eval_pending;
    logic              mem_we;
    logic [2*CW-1:0]   rd_a, rd_b;

    assign accept = start && !busy;

    // Relation count clamped to one at the bottom and to MAX_RELATIONS at the top.
    always_comb begin
        rc_ext = 5'(r_rel_count);
        if (rc_ext == 5'd0) begin
            n_eff = 5'd1;
        end else if (rc_ext > 5'(MR)) begin
            n_eff = 5'(MR);
        end else begin
            n_eff = rc_ext;
        end
        for (int i = 0; i < MR; i++) begin
            mask[i] = (5'(i) < n_eff);
        end
    end

    // An all-ones size is treated as unconnected; larger finite sizes saturate.
    always_comb begin
        raw_e     = EW'(i_subset_size);
        in_unconn = i_unconnected || (i_subset_size == {FIELD_W{1'b1}});
        if (in_unconn) begin
            in_size = COST_INF;
        end else if (raw_e > MAXFIN_E) begin
            in_size = COST_MAXFIN;
        end else begin
            in_size = CW'(raw_e);
        end
    end

    always_comb begin
        smear = r_size;
        for (int sh = 1; sh < CW; sh = sh * 2) begin
            smear = smear | (smear >> sh);
        end
        pow = smear ^ (smear >> 1);
    end

    always_comb begin
        trivial    = ((r_s & (r_s - 1'b1)) == '0);
        pruned     = (r_cost_mode == MODE_MIN_PLUS) && (EW'(r_size) > EW'(r_size_cap));
        a_next     = (r_a - 1'b1) & r_s;
        last_split = (a_next == '0);
    end

    always_comb begin
        final_sum = {1'b0, eval_best} + {1'b0, r_size};
        if (eval_best == COST_INF) begin
            final_best = COST_INF;
        end else begin
            case (r_cost_mode)
                MODE_MIN_PLUS: final_best = (final_sum > {1'b0, COST_MAXFIN}) ?
                                            COST_MAXFIN : final_sum[CW-1:0];
                MODE_MIN_MAX:  final_best = (eval_best > r_size) ? eval_best : r_size;
                MODE_HASH:     final_best = eval_best;
                MODE_APPROX:   final_best = (eval_best > r_pow) ? eval_best : r_pow;
                default:       final_best = eval_best;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (trivial || r_unconn || pruned) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (last_split) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_rd_vld && !eval_pending) n_state = S_FINAL;
            end
            S_FINAL: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy           = (r_state != S_IDLE);
        issue          = (r_state == S_SCAN);
        mem_we         = (r_state == S_DONE);
        o_result_valid = (r_state == S_DONE);
        eval_ctl.clear    = (r_state == S_SETUP);
        eval_ctl.load_vld = r_rd_vld;
        eval_ctl.mode     = r_cost_mode;
        o_cost_finite  = (r_best != COST_INF);
        o_subset_cost  = o_cost_finite ? FIELD_W'(EW'(r_best)) : '0;
        o_full_set     = (r_s == r_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cost_mode <= MODE_MIN_PLUS;
            r_rel_count <= 4'd12;
            r_size_cap  <= {FIELD_W{1'b1}};
            r_counter   <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_COST_MODE:      r_cost_mode <= t_mode'(i_cfg_wdata[1:0]);
                    CFG_RELATION_COUNT: r_rel_count <= i_cfg_wdata[3:0];
                    CFG_SIZE_CAP:       r_size_cap  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_DONE) begin
                r_counter <= (r_s == r_mask) ? '0 : r_s + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s      <= r_counter & mask;
            r_mask   <= mask;
            r_size   <= in_size;
            r_unconn <= in_unconn;
        end
        if (r_state == S_SETUP) begin
            r_a    <= (r_s - 1'b1) & r_s;
            r_pow  <= pow;
            r_best <= trivial ? '0 : COST_INF;
        end
        if (r_state == S_SCAN) begin
            r_a <= a_next;
        end
        if (r_state == S_FINAL) begin
            r_best <= final_best;
        end
    end

    sdjo_table #(
        .AW (MR),
        .DW (2 * CW)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_s),
        .i_wdata   ({r_size, r_best}),
        .i_raddr_a (r_a),
        .i_raddr_b (r_s ^ r_a),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    sdjo_split_eval #(
        .CW (CW)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (eval_ctl),
        .i_rd_a    (rd_a),
        .i_rd_b    (rd_b),
        .o_best    (eval_best),
        .o_pending (eval_pending)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_SETUP))
        else $error("accepted transaction did not enter setup");

    a_scan_submask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_a != '0) && ((r_a & ~r_s) == '0)))
        else $error("scan address is not a nonempty submask of the subset");

    a_full_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_full_set) |=> (r_counter == '0))
        else $error("subset counter did not wrap after the full set");

    a_final_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> (!r_rd_vld && !eval_pending))
        else $error("final step reached with splits still in flight");

endmodule
